// ===== sv/aztec_text_symbol_placer_unit_macros.svh =====
// Assertion macros for the text placer checks.
`ifndef AZTEC_TEXT_SYMBOL_PLACER_UNIT_MACROS_SVH
`define AZTEC_TEXT_SYMBOL_PLACER_UNIT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ATSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ATSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/atsp_pkg.sv =====
package atsp_pkg;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_UPPER = 2'd1,
        MODE_LOWER = 2'd2,
        MODE_DIGIT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_TOP    = 2'd3
    } t_side;

    typedef enum logic [2:0] {
        K_LAT_U = 3'd0,
        K_LAT_L = 3'd1,
        K_LAT_D = 3'd2,
        K_CHAR  = 3'd3,
        K_INV   = 3'd4
    } t_kind;

    typedef logic [2:0] t_addr;

    typedef struct packed {
        t_kind kind;
        logic  last_w;
        t_addr next;
    } t_uop;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        t_side      side;
    } t_cur;

    // microprogram entry points
    localparam t_addr A_LU  = 3'd0;  // upper latch, then char
    localparam t_addr A_LL  = 3'd1;  // lower latch, then char
    localparam t_addr A_LD  = 3'd2;  // digit latch, then char
    localparam t_addr A_LDU = 3'd3;  // digit latch, then upper latch
    localparam t_addr A_LUL = 3'd4;  // upper latch, then lower latch
    localparam t_addr A_CHR = 3'd5;  // character code, end
    localparam t_addr A_INV = 3'd6;  // invalid result, end

    localparam logic [7:0] UPPER_BIAS = 8'd63;
    localparam logic [7:0] LOWER_BIAS = 8'd95;
    localparam logic [7:0] DIGIT_BIAS = 8'd46;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_PERIOD  = 8'd46;

    function automatic t_uop uop_rom(input t_addr a);
        t_uop u;
        case (a)
            A_LU:    u = '{kind: K_LAT_U, last_w: 1'b0, next: A_CHR};
            A_LL:    u = '{kind: K_LAT_L, last_w: 1'b0, next: A_CHR};
            A_LD:    u = '{kind: K_LAT_D, last_w: 1'b0, next: A_CHR};
            A_LDU:   u = '{kind: K_LAT_D, last_w: 1'b0, next: A_LU};
            A_LUL:   u = '{kind: K_LAT_U, last_w: 1'b0, next: A_LL};
            A_CHR:   u = '{kind: K_CHAR,  last_w: 1'b1, next: A_CHR};
            default: u = '{kind: K_INV,   last_w: 1'b1, next: A_INV};
        endcase
        return u;
    endfunction

    function automatic t_mode char_class(input logic [7:0] c);
        t_mode m;
        if (c >= 8'd65 && c <= 8'd90) begin
            m = MODE_UPPER;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            m = MODE_LOWER;
        end else if ((c >= 8'd48 && c <= 8'd57) || c == CH_COMMA || c == CH_PERIOD) begin
            m = MODE_DIGIT;
        end else begin
            m = MODE_INIT;
        end
        return m;
    endfunction

    // entry point chosen from current mode and character class
    function automatic t_addr dispatch(input t_mode mode, input t_mode cls);
        t_addr a;
        if (cls == MODE_INIT) begin
            a = A_INV;
        end else if (mode == MODE_INIT) begin
            case (cls)
                MODE_UPPER: a = A_LU;
                MODE_LOWER: a = A_LL;
                default:    a = A_LD;
            endcase
        end else if (mode == cls) begin
            a = A_CHR;
        end else begin
            case (mode)
                MODE_UPPER: a = A_LD;
                MODE_LOWER: a = (cls == MODE_UPPER) ? A_LDU : A_LD;
                default:    a = (cls == MODE_LOWER) ? A_LUL : A_LU;
            endcase
            if (mode == MODE_UPPER && cls == MODE_LOWER) begin
                a = A_LL;
            end
        end
        return a;
    endfunction

    function automatic logic [4:0] code_value(input t_kind k, input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] v;
        d = 8'd0;
        case (k)
            K_LAT_U: v = 5'd14;
            K_LAT_L: v = 5'd28;
            K_LAT_D: v = 5'd30;
            K_CHAR: begin
                case (char_class(c))
                    MODE_UPPER: d = c - UPPER_BIAS;
                    MODE_LOWER: d = c - LOWER_BIAS;
                    default: begin
                        if (c == CH_COMMA) d = 8'd12;
                        else if (c == CH_PERIOD) d = 8'd13;
                        else d = {4'd0, 4'(c - DIGIT_BIAS)};
                    end
                endcase
                v = d[4:0];
            end
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // top bit index of the code
    function automatic logic [2:0] code_top(input t_kind k, input logic [7:0] c);
        logic [2:0] t;
        case (k)
            K_LAT_U: t = 3'd3;
            K_LAT_L: t = 3'd4;
            K_LAT_D: t = 3'd4;
            K_CHAR:  t = (char_class(c) == MODE_DIGIT) ? 3'd3 : 3'd4;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/aztec_text_symbol_placer_unit.sv =====
// Channel   | Dir | Fields (low bit up)
// s_axis    | in  | tdata[7:0] char_code
// m_axis    | out | tdata[3:0] row, [7:4] col, [8] cell_bit; tlast last; tuser invalid
//
// One item at a time; a character makes one placement per code bit (4 to 14,
// one item for an invalid character), paced by the microprogram step counter
// that emits one code bit per cycle into the output register while m_axis is not stalled.
// Reset (synchronous, active low) clears mode, cursor and handshake state.
// A stall on m_axis holds the sequencer; s_axis is taken only when idle.
module aztec_text_symbol_placer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] row, [7:4] col, [8] cell_bit
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] invalid
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state          r_state, n_state;
    atsp_pkg::t_mode r_mode, n_mode;
    atsp_pkg::t_cur  r_cur, n_cur;
    atsp_pkg::t_addr r_upc, n_upc;
    logic [2:0]      r_idx, n_idx;
    logic            r_load, n_load;
    logic [7:0]      r_char, n_char;
    logic            r_ov, n_ov;
    logic [3:0]      r_orow, n_orow;
    logic [3:0]      r_ocol, n_ocol;
    logic            r_obit, n_obit;
    logic            r_olast, n_olast;
    logic            r_oinv, n_oinv;

    atsp_pkg::t_uop  uop;
    atsp_pkg::t_mode in_cls;
    atsp_pkg::t_cur  adv;
    logic [4:0]      code;
    logic [2:0]      idx;
    logic            slot_free;

    function automatic atsp_pkg::t_cur advance(input atsp_pkg::t_cur c);
        atsp_pkg::t_cur n;
        n = c;
        case (c.side)
            atsp_pkg::SIDE_LEFT: begin
                if (c.col == 4'd0) begin
                    n.col = 4'd1;
                end else begin
                    n.col = 4'd0;
                    n.row = c.row + 4'd1;
                    if (n.row == 4'd13) begin
                        n.row  = 4'd14;
                        n.side = atsp_pkg::SIDE_BOTTOM;
                    end
                end
            end
            atsp_pkg::SIDE_BOTTOM: begin
                if (c.row == 4'd14) begin
                    n.row = 4'd13;
                end else begin
                    n.row = 4'd14;
                    n.col = c.col + 4'd1;
                    if (n.col == 4'd13) begin
                        n.col  = 4'd14;
                        n.side = atsp_pkg::SIDE_RIGHT;
                    end
                end
            end
            atsp_pkg::SIDE_RIGHT: begin
                if (c.col == 4'd14) begin
                    n.col = 4'd13;
                end else begin
                    n.col = 4'd14;
                    n.row = c.row - 4'd1;
                    if (n.row == 4'd1) begin
                        n.row  = 4'd0;
                        n.side = atsp_pkg::SIDE_TOP;
                    end
                end
            end
            default: begin
                if (c.row == 4'd0) begin
                    n.row = 4'd1;
                end else begin
                    n.row = 4'd0;
                    n.col = c.col - 4'd1;
                    if (n.col == 4'd1) begin
                        n.col  = 4'd0;
                        n.side = atsp_pkg::SIDE_LEFT;
                    end
                end
            end
        endcase
        return n;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_obit, r_ocol, r_orow};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oinv;

    assign slot_free = !r_ov || m_axis_tready;
    assign uop       = atsp_pkg::uop_rom(r_upc);
    assign in_cls    = atsp_pkg::char_class(s_axis_tdata);
    assign adv       = advance(r_cur);
    assign code      = atsp_pkg::code_value(uop.kind, r_char);
    assign idx       = r_load ? atsp_pkg::code_top(uop.kind, r_char) : r_idx;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cur   = r_cur;
        n_upc   = r_upc;
        n_idx   = r_idx;
        n_load  = r_load;
        n_char  = r_char;
        n_ov    = r_ov && !m_axis_tready;
        n_orow  = r_orow;
        n_ocol  = r_ocol;
        n_obit  = r_obit;
        n_olast = r_olast;
        n_oinv  = r_oinv;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_char  = s_axis_tdata;
                    n_upc   = atsp_pkg::dispatch(r_mode, in_cls);
                    n_load  = 1'b1;
                    n_state = ST_RUN;
                    if (r_mode == atsp_pkg::MODE_INIT && in_cls != atsp_pkg::MODE_INIT) begin
                        n_cur.row = 4'd0;
                        n_cur.col = 4'd1;
                    end
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    if (uop.kind == atsp_pkg::K_INV) begin
                        n_orow  = 4'd0;
                        n_ocol  = 4'd0;
                        n_obit  = 1'b0;
                        n_olast = 1'b0;
                        n_oinv  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_cur   = adv;
                        n_orow  = adv.row;
                        n_ocol  = adv.col;
                        n_obit  = code[idx];
                        n_oinv  = 1'b0;
                        n_olast = 1'b0;
                        if (r_load) begin
                            case (uop.kind)
                                atsp_pkg::K_LAT_U: n_mode = atsp_pkg::MODE_UPPER;
                                atsp_pkg::K_LAT_L: n_mode = atsp_pkg::MODE_LOWER;
                                atsp_pkg::K_LAT_D: n_mode = atsp_pkg::MODE_DIGIT;
                                default:           n_mode = r_mode;
                            endcase
                        end
                        if (idx == 3'd0) begin
                            n_load = 1'b1;
                            if (uop.last_w) begin
                                n_olast = 1'b1;
                                n_state = ST_IDLE;
                            end else begin
                                n_upc = uop.next;
                            end
                        end else begin
                            n_idx  = idx - 3'd1;
                            n_load = 1'b0;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= atsp_pkg::MODE_INIT;
            r_cur   <= '{row: 4'd0, col: 4'd0, side: atsp_pkg::SIDE_LEFT};
            r_ov    <= 1'b0;
            r_load  <= 1'b1;
            r_upc   <= atsp_pkg::A_INV;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_cur   <= n_cur;
            r_ov    <= n_ov;
            r_load  <= n_load;
            r_upc   <= n_upc;
            r_idx   <= n_idx;
        end
        r_char  <= n_char;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_obit  <= n_obit;
        r_olast <= n_olast;
        r_oinv  <= n_oinv;
    end

endmodule

// ===== sv/atsp_checker.sv =====
`include "aztec_text_symbol_placer_unit_macros.svh"

module atsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    `ATSP_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output item changed")
    `ATSP_ASSERT(a_inv_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0 && !m_axis_tlast, "invalid item carries placement data")
    `ATSP_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while one is in work")
    `ATSP_ASSERT(a_on_grid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3:0] != 4'd15 && m_axis_tdata[7:4] != 4'd15 && m_axis_tdata[15:9] == 7'd0, "placement off the grid")
    `ATSP_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

endmodule

bind aztec_text_symbol_placer_unit atsp_checker u_atsp_checker (.*);

// ===== bench/aztec_text_symbol_placer_unit_test.sv =====
`default_nettype none

module aztec_text_symbol_placer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] CODE_LATCH_UPPER = 5'd14;
    localparam logic [4:0] CODE_LATCH_LOWER = 5'd28;
    localparam logic [4:0] CODE_LATCH_DIGIT = 5'd30;
    localparam logic [4:0] CODE_COMMA       = 5'd12;
    localparam logic [4:0] CODE_PERIOD      = 5'd13;
    localparam logic [7:0] ASCII_UPPER_A    = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z    = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A    = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z    = 8'd122;
    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_NINE       = 8'd57;
    localparam logic [7:0] ASCII_COMMA      = 8'd44;
    localparam logic [7:0] ASCII_PERIOD     = 8'd46;
    localparam int         DRAIN_CYCLES     = 40;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic       dark;
        logic       last;
        logic       invalid;
    } t_placement;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [3:0] row, [7:4] col, [8] cell_bit
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] invalid

    // text mode and ring cursor as the block should hold them
    atsp_pkg::t_mode text_mode;
    atsp_pkg::t_side walk_side;
    logic [3:0]      cur_row;
    logic [3:0]      cur_col;

    t_placement pending_cells[$];
    int         mismatches;
    int         tx_idle_max;
    int         rx_idle_max;

    aztec_text_symbol_placer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic atsp_pkg::t_mode char_mode(input logic [7:0] c);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return atsp_pkg::MODE_UPPER;
        end
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            return atsp_pkg::MODE_LOWER;
        end
        if ((c >= ASCII_ZERO && c <= ASCII_NINE) || c == ASCII_COMMA || c == ASCII_PERIOD) begin
            return atsp_pkg::MODE_DIGIT;
        end
        return atsp_pkg::MODE_INIT;
    endfunction

    function automatic void step_cursor();
        case (walk_side)
            atsp_pkg::SIDE_LEFT: begin
                if (cur_col == 4'd0) begin
                    cur_col = 4'd1;
                end else begin
                    cur_col = 4'd0;
                    cur_row = cur_row + 4'd1;
                    if (cur_row == 4'd13) begin
                        cur_row = 4'd14;
                        walk_side = atsp_pkg::SIDE_BOTTOM;
                    end
                end
            end
            atsp_pkg::SIDE_BOTTOM: begin
                if (cur_row == 4'd14) begin
                    cur_row = 4'd13;
                end else begin
                    cur_row = 4'd14;
                    cur_col = cur_col + 4'd1;
                    if (cur_col == 4'd13) begin
                        cur_col = 4'd14;
                        walk_side = atsp_pkg::SIDE_RIGHT;
                    end
                end
            end
            atsp_pkg::SIDE_RIGHT: begin
                if (cur_col == 4'd14) begin
                    cur_col = 4'd13;
                end else begin
                    cur_col = 4'd14;
                    cur_row = cur_row - 4'd1;
                    if (cur_row == 4'd1) begin
                        cur_row = 4'd0;
                        walk_side = atsp_pkg::SIDE_TOP;
                    end
                end
            end
            default: begin
                if (cur_row == 4'd0) begin
                    cur_row = 4'd1;
                end else begin
                    cur_row = 4'd0;
                    cur_col = cur_col - 4'd1;
                    if (cur_col == 4'd1) begin
                        cur_col = 4'd0;
                        walk_side = atsp_pkg::SIDE_LEFT;
                    end
                end
            end
        endcase
    endfunction

    // msb first, one placement per bit
    function automatic void place_code(input logic [4:0] code, input int nbits,
                                       input logic ends);
        t_placement p;
        for (int i = nbits - 1; i >= 0; i--) begin
            step_cursor();
            p.row     = cur_row;
            p.col     = cur_col;
            p.dark    = code[i];
            p.last    = ends && (i == 0);
            p.invalid = 1'b0;
            pending_cells.insert(pending_cells.size(), p);
        end
    endfunction

    function automatic void predict_placements(input logic [7:0] c);
        atsp_pkg::t_mode cls;
        logic [7:0]      code;
        t_placement      p;
        cls = char_mode(c);
        if (cls == atsp_pkg::MODE_INIT) begin
            p = '0;
            p.invalid = 1'b1;
            pending_cells.insert(pending_cells.size(), p);
            return;
        end
        if (text_mode == atsp_pkg::MODE_INIT) begin
            cur_row = 4'd0;
            cur_col = 4'd1;
            case (cls)
                atsp_pkg::MODE_UPPER: place_code(CODE_LATCH_UPPER, 4, 1'b0);
                atsp_pkg::MODE_LOWER: place_code(CODE_LATCH_LOWER, 5, 1'b0);
                default:              place_code(CODE_LATCH_DIGIT, 5, 1'b0);
            endcase
        end else if (text_mode != cls) begin
            case (text_mode)
                atsp_pkg::MODE_UPPER: begin
                    if (cls == atsp_pkg::MODE_LOWER) begin
                        place_code(CODE_LATCH_LOWER, 5, 1'b0);
                    end else begin
                        place_code(CODE_LATCH_DIGIT, 5, 1'b0);
                    end
                end
                atsp_pkg::MODE_LOWER: begin
                    place_code(CODE_LATCH_DIGIT, 5, 1'b0);
                    if (cls == atsp_pkg::MODE_UPPER) begin
                        place_code(CODE_LATCH_UPPER, 4, 1'b0);
                    end
                end
                default: begin
                    place_code(CODE_LATCH_UPPER, 4, 1'b0);
                    if (cls == atsp_pkg::MODE_LOWER) begin
                        place_code(CODE_LATCH_LOWER, 5, 1'b0);
                    end
                end
            endcase
        end
        text_mode = cls;
        case (cls)
            atsp_pkg::MODE_UPPER: begin
                code = c - 8'd63;
                place_code(code[4:0], 5, 1'b1);
            end
            atsp_pkg::MODE_LOWER: begin
                code = c - 8'd95;
                place_code(code[4:0], 5, 1'b1);
            end
            default: begin
                if (c == ASCII_COMMA) begin
                    code = {3'd0, CODE_COMMA};
                end else if (c == ASCII_PERIOD) begin
                    code = {3'd0, CODE_PERIOD};
                end else begin
                    code = {4'd0, 4'(c - 8'd46)};
                end
                place_code(code[4:0], 4, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // input items feed the prediction, output items are checked in order
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_placements(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected item tdata=%h tlast=%b tuser=%b",
                                              m_axis_tdata, m_axis_tlast, m_axis_tuser));
                end else begin
                    want = pending_cells.pop_front();
                    if (m_axis_tdata[3:0] !== want.row) begin
                        report_mismatch($sformatf("row %0d, want %0d",
                                                  m_axis_tdata[3:0], want.row));
                    end
                    if (m_axis_tdata[7:4] !== want.col) begin
                        report_mismatch($sformatf("col %0d, want %0d",
                                                  m_axis_tdata[7:4], want.col));
                    end
                    if (m_axis_tdata[8] !== want.dark) begin
                        report_mismatch($sformatf("cell_bit %b, want %b",
                                                  m_axis_tdata[8], want.dark));
                    end
                    if (m_axis_tdata[15:9] !== 7'd0) begin
                        report_mismatch($sformatf("tdata pad bits %b", m_axis_tdata[15:9]));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("tlast %b, want %b",
                                                  m_axis_tlast, want.last));
                    end
                    if (m_axis_tuser !== want.invalid) begin
                        report_mismatch($sformatf("invalid %b, want %b",
                                                  m_axis_tuser, want.invalid));
                    end
                end
            end
        end
    end

    // receiver: random stall before each output item
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, rx_idle_max);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic apply_reset();
        text_mode   = atsp_pkg::MODE_INIT;
        walk_side   = atsp_pkg::SIDE_LEFT;
        cur_row     = 4'd0;
        cur_col     = 4'd0;
        mismatches  = 0;
        tx_idle_max = 15;
        rx_idle_max = 15;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // invalid while still in initial mode, then the first real character
    task automatic test_first_character();
        logic [7:0] first [3];
        first = '{8'h41, 8'h61, 8'h30};
        send_char(8'hFF);
        send_char(first[$urandom_range(0, 2)]);
    endtask

    // every latch path between the three modes plus staying in mode
    task automatic test_latch_paths();
        logic [7:0] text [12];
        text = '{"A", "Z", "a", "z", "A", "0", "9", ",", ".", "a", "5", "Z"};
        foreach (text[i]) begin
            send_char(text[i]);
        end
    endtask

    task automatic test_invalid_characters();
        logic [7:0] junk [11];
        junk = '{8'h00, 8'hFF, 8'd64, 8'd91, 8'd96, 8'd123, 8'd47, 8'd58, 8'd45,
                 8'd43, 8'h80};
        foreach (junk[i]) begin
            send_char(junk[i]);
        end
    endtask

    // mostly runs of one class with latches between, some raw bytes
    task automatic test_random_text();
        atsp_pkg::t_mode run_mode;
        logic [7:0]      c;
        int              pick;
        run_mode = atsp_pkg::MODE_UPPER;
        for (int i = 0; i < 480; i++) begin
            case ((i / 60) % 4)
                0: begin tx_idle_max = 15; rx_idle_max = 15; end
                1: begin tx_idle_max = 0;  rx_idle_max = 0;  end
                2: begin tx_idle_max = 0;  rx_idle_max = 15; end
                default: begin tx_idle_max = 15; rx_idle_max = 0; end
            endcase
            if ($urandom_range(0, 99) < 8) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                if ($urandom_range(0, 9) < 3) begin
                    run_mode = atsp_pkg::t_mode'($urandom_range(1, 3));
                end
                case (run_mode)
                    atsp_pkg::MODE_UPPER: c = ASCII_UPPER_A + 8'($urandom_range(0, 25));
                    atsp_pkg::MODE_LOWER: c = ASCII_LOWER_A + 8'($urandom_range(0, 25));
                    default: begin
                        pick = $urandom_range(0, 11);
                        if (pick == 10) begin
                            c = ASCII_COMMA;
                        end else if (pick == 11) begin
                            c = ASCII_PERIOD;
                        end else begin
                            c = ASCII_ZERO + 8'(pick);
                        end
                    end
                endcase
            end
            send_char(c);
        end
    endtask

    initial begin
        apply_reset();
        test_first_character();
        test_latch_paths();
        test_invalid_characters();
        test_random_text();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
